// File: rtl/dpce_pkg.sv
// ----------------------------------------------------------------------------
// dpce_pkg
// types, register codes and the dshot frame function of the channel encoder
// ----------------------------------------------------------------------------
package dpce_pkg;

  localparam int unsigned DATA_W   = 16;
  localparam int unsigned FRAME_W  = 16;
  localparam int unsigned CH_IN_W  = 4;
  localparam int unsigned CH_OUT_W = 3;
  localparam int unsigned CFG_IX_W = 3;
  localparam int unsigned DIV_W    = 32;
  localparam int unsigned PI_W     = 7;
  localparam int unsigned PROD_W   = 23;
  localparam int unsigned RECIP_W  = 24;
  localparam int unsigned RECIP_SH = 30;

  localparam logic [DATA_W-1:0]  PCT_FULL_Q8  = 16'd25600;
  // ceil(2^30 / 100), exact for every product below 2^23
  localparam logic [RECIP_W-1:0] PCT_RECIP    = 24'd10737419;
  localparam logic [10:0]        DSHOT_OFFSET = 11'd47;
  localparam logic [DATA_W-1:0]  SAT_VALUE    = 16'hFFFF;

  typedef enum logic [CFG_IX_W-1:0] {
    CFG_MIN_PULSE    = 3'd0,
    CFG_MAX_PULSE    = 3'd1,
    CFG_FRAME_PERIOD = 3'd2,
    CFG_TIMER_PERIOD = 3'd3,
    CFG_ONE_DUTY     = 3'd4,
    CFG_ZERO_DUTY    = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL1,
    F_DIV1,
    F_MUL2,
    F_DIV2,
    F_PUSH
  } front_state_e;

  typedef struct packed {
    logic [DATA_W-1:0] min_pulse_us;
    logic [DATA_W-1:0] max_pulse_us;
    logic [DATA_W-1:0] frame_period_us;
    logic [DATA_W-1:0] timer_period_ticks;
    logic [DATA_W-1:0] one_bit_duty;
    logic [DATA_W-1:0] zero_bit_duty;
  } cfg_t;

  typedef struct packed {
    logic [CH_OUT_W-1:0] channel;
    logic                is_dshot;
    logic [DATA_W-1:0]   value;
  } job_t;

  typedef struct packed {
    logic push;
    logic full;
  } queue_ctl_t;

  // p is already saturated to full throttle
  function automatic logic [FRAME_W-1:0] dshot_frame(input logic [DATA_W-1:0] p);
    logic [18:0] scaled;
    logic [10:0] thr;
    logic [11:0] f;
    logic [3:0]  crc;
    scaled = 19'(p) * 19'd5;
    thr    = scaled[16:6];
    f      = {thr + DSHOT_OFFSET, 1'b0};
    crc    = f[3:0] ^ f[7:4] ^ f[11:8];
    return {f, crc};
  endfunction

endpackage

// File: rtl/dpce_div.sv
// ----------------------------------------------------------------------------
// dpce_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module dpce_div
  import dpce_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DIV_W-1:0]  quotient_o
);

  localparam int unsigned CntW = $clog2(DIV_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] dvs_q, dvs_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   rem_sub;
  logic              ge;

  assign rem_sh  = {rem_q, quo_q[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign ge      = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/dpce_front.sv
// ----------------------------------------------------------------------------
// dpce_front
// accepts requests, picks dshot or servo and works out the job value
// ----------------------------------------------------------------------------
module dpce_front
  import dpce_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS       = 8,
  parameter int unsigned NUM_DSHOT_CHANNELS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [CH_IN_W-1:0] channel_i,
  input  logic [DATA_W-1:0]  percent_q8_i,
  input  logic               queue_full_i,
  output queue_ctl_t         queue_ctl_o,
  output job_t               job_o
);

  localparam logic [CH_IN_W:0] NumCh    = (CH_IN_W+1)'(NUM_CHANNELS);
  localparam logic [CH_IN_W:0] NumDshot = (CH_IN_W+1)'(NUM_DSHOT_CHANNELS);
  localparam int unsigned      ScaledW  = PROD_W + RECIP_W;

  front_state_e state_q, state_d;

  logic [CH_IN_W-1:0]  ch_eff;
  logic [DATA_W-1:0]   p_sat;
  logic                is_dshot;
  logic                accept;
  logic [CH_OUT_W-1:0] ch_q, ch_d;
  logic [PI_W-1:0]     pi_q, pi_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [DATA_W-1:0]   us_q, us_d;
  logic [DATA_W-1:0]   val_q, val_d;
  logic                up;
  logic [DATA_W-1:0]   diff;
  logic [PROD_W-1:0]   mul1;
  logic [ScaledW-1:0]  scaled;
  logic [DATA_W-1:0]   pct_quo;
  logic [DIV_W-1:0]    mul2;
  logic                div_start;
  logic [DIV_W-1:0]    div_dividend;
  logic [DATA_W-1:0]   div_divisor;
  logic                div_done;
  logic [DIV_W-1:0]    div_quo;

  assign ch_eff   = ({1'b0, channel_i} >= NumCh) ? '0 : channel_i;
  assign p_sat    = (percent_q8_i > PCT_FULL_Q8) ? PCT_FULL_Q8 : percent_q8_i;
  assign is_dshot = {1'b0, ch_eff} < NumDshot;
  assign busy_o   = (state_q != F_IDLE) || queue_full_i;
  assign accept   = start_i && !busy_o;

  assign up      = cfg_i.max_pulse_us >= cfg_i.min_pulse_us;
  assign diff    = up ? (cfg_i.max_pulse_us - cfg_i.min_pulse_us)
                      : (cfg_i.min_pulse_us - cfg_i.max_pulse_us);
  assign mul1    = PROD_W'(pi_q) * PROD_W'(diff);
  // divide by 100 through the reciprocal
  assign scaled  = ScaledW'(prod_q) * ScaledW'(PCT_RECIP);
  assign pct_quo = scaled[RECIP_SH +: DATA_W];
  assign mul2    = DIV_W'(us_q) * DIV_W'(cfg_i.timer_period_ticks);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept && !is_dshot) state_d = F_MUL1;
      end
      F_MUL1: state_d = F_DIV1;
      F_DIV1: state_d = F_MUL2;
      F_MUL2: state_d = F_DIV2;
      F_DIV2: begin
        if (div_done) state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!queue_full_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    div_start        = 1'b0;
    div_dividend     = mul2;
    div_divisor      = cfg_i.frame_period_us;
    queue_ctl_o.push = 1'b0;
    queue_ctl_o.full = queue_full_i;
    job_o.channel    = ch_q;
    job_o.is_dshot   = 1'b0;
    job_o.value      = val_q;
    ch_d             = ch_q;
    pi_d             = pi_q;
    prod_d           = prod_q;
    us_d             = us_q;
    val_d            = val_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          ch_d = ch_eff[CH_OUT_W-1:0];
          pi_d = p_sat[8 +: PI_W];
          if (is_dshot) begin
            queue_ctl_o.push = 1'b1;
            job_o.channel    = ch_eff[CH_OUT_W-1:0];
            job_o.is_dshot   = 1'b1;
            job_o.value      = dshot_frame(p_sat);
          end
        end
      end
      F_MUL1: begin
        prod_d = mul1;
      end
      F_DIV1: begin
        us_d = up ? (cfg_i.min_pulse_us + pct_quo)
                  : (cfg_i.min_pulse_us - pct_quo);
      end
      F_MUL2: begin
        div_start = 1'b1;
      end
      F_DIV2: begin
        if (div_done) begin
          val_d = (div_quo[DIV_W-1:DATA_W] != '0) ? SAT_VALUE : div_quo[DATA_W-1:0];
        end
      end
      F_PUSH: begin
        queue_ctl_o.push = !queue_full_i;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    pi_q   <= pi_d;
    prod_q <= prod_d;
    us_q   <= us_d;
    val_q  <= val_d;
  end

  dpce_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

endmodule

// File: rtl/dpce_queue.sv
// ----------------------------------------------------------------------------
// dpce_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module dpce_queue
  import dpce_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  queue_ctl_t ctl_i,
  input  job_t       job_i,
  output logic       full_o,
  output logic       empty_o,
  input  logic       pop_i,
  output job_t       job_o
);

  job_t       mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push;
  logic       do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = ctl_i.push && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? !wr_q : wr_q;
    rd_d  = do_pop ? !rd_q : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= job_i;
  end

  assign job_o = mem_q[rd_q];

endmodule

// File: rtl/dpce_back.sv
// ----------------------------------------------------------------------------
// dpce_back
// turns queued jobs into timer compare words, one per cycle
// ----------------------------------------------------------------------------
module dpce_back
  import dpce_pkg::*;
#(
  parameter int unsigned BUFFER_WORDS = 18
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                empty_i,
  output logic                pop_o,
  input  job_t                job_i,
  output logic                result_strobe_o,
  output logic [CH_OUT_W-1:0] channel_out_o,
  output logic [DATA_W-1:0]   compare_value_o,
  output logic                is_dshot_o,
  output logic                last_o
);

  localparam int unsigned CntW = $clog2(BUFFER_WORDS);

  logic                active_q, active_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [FRAME_W-1:0]  frame_q, frame_d;
  logic [CH_OUT_W-1:0] ch_q, ch_d;
  logic                dshot_q, dshot_d;
  logic                strobe_q, strobe_d;
  logic [CH_OUT_W-1:0] och_q, och_d;
  logic [DATA_W-1:0]   oval_q, oval_d;
  logic                odshot_q, odshot_d;
  logic                olast_q, olast_d;
  logic                word_last;

  assign word_last = !dshot_q || (cnt_q == CntW'(BUFFER_WORDS - 1));
  assign pop_o     = !empty_i && (!active_q || word_last);

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    frame_d  = frame_q;
    ch_d     = ch_q;
    dshot_d  = dshot_q;
    strobe_d = active_q;
    och_d    = ch_q;
    odshot_d = dshot_q;
    olast_d  = word_last;
    oval_d   = frame_q;
    if (dshot_q) begin
      if (32'(cnt_q) < FRAME_W) begin
        oval_d = frame_q[FRAME_W-1] ? cfg_i.one_bit_duty : cfg_i.zero_bit_duty;
      end else begin
        oval_d = '0;
      end
    end
    if (active_q) begin
      cnt_d   = cnt_q + 1'b1;
      frame_d = {frame_q[FRAME_W-2:0], 1'b0};
      if (word_last) active_d = 1'b0;
    end
    if (pop_o) begin
      active_d = 1'b1;
      cnt_d    = '0;
      frame_d  = job_i.value;
      ch_d     = job_i.channel;
      dshot_d  = job_i.is_dshot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      strobe_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      strobe_q <= strobe_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q  <= frame_d;
    ch_q     <= ch_d;
    dshot_q  <= dshot_d;
    och_q    <= och_d;
    oval_q   <= oval_d;
    odshot_q <= odshot_d;
    olast_q  <= olast_d;
  end

  assign result_strobe_o = strobe_q;
  assign channel_out_o   = och_q;
  assign compare_value_o = oval_q;
  assign is_dshot_o      = odshot_q;
  assign last_o          = olast_q;

endmodule

// File: rtl/dshot_pwm_channel_encoder_unit.sv
// ----------------------------------------------------------------------------
// dshot_pwm_channel_encoder_unit
// dshot150 frame and servo pwm compare word encoder
//
//   channel   handshake                  payload
//   request   start / busy               channel_i, percent_q8_i
//   result    result_strobe_o            channel_out_o, compare_value_o,
//                                        is_dshot_o, last_o
//   config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// a dshot request gives BUFFER_WORDS words on consecutive cycles once past the
// queue entry, back job and output registers; the front takes one dshot
// request per cycle while the two-entry queue has room, so the word stream
// sets the sustained rate; a servo request holds the front until its push,
// one 32-step pass of the divider for the tick count, and its one word takes
// the same path; reset loads the register defaults; results cannot be stalled
// ----------------------------------------------------------------------------
module dshot_pwm_channel_encoder_unit
  import dpce_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS       = 8,
  parameter int unsigned NUM_DSHOT_CHANNELS = 4,
  parameter int unsigned BUFFER_WORDS       = 18
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [CH_IN_W-1:0]  channel_i,
  input  logic [DATA_W-1:0]   percent_q8_i,
  output logic                result_strobe_o,
  output logic [CH_OUT_W-1:0] channel_out_o,
  output logic [DATA_W-1:0]   compare_value_o,
  output logic                is_dshot_o,
  output logic                last_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_IX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]   cfg_data_i
);

  cfg_t       cfg_q, cfg_d;
  queue_ctl_t qctl;
  job_t       job_in;
  job_t       job_out;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MIN_PULSE:    cfg_d.min_pulse_us       = cfg_data_i;
        CFG_MAX_PULSE:    cfg_d.max_pulse_us       = cfg_data_i;
        CFG_FRAME_PERIOD: cfg_d.frame_period_us    = cfg_data_i;
        CFG_TIMER_PERIOD: cfg_d.timer_period_ticks = cfg_data_i;
        CFG_ONE_DUTY:     cfg_d.one_bit_duty       = cfg_data_i;
        CFG_ZERO_DUTY:    cfg_d.zero_bit_duty      = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_pulse_us       <= 16'd1000;
      cfg_q.max_pulse_us       <= 16'd2000;
      cfg_q.frame_period_us    <= 16'd20000;
      cfg_q.timer_period_ticks <= 16'd60000;
      cfg_q.one_bit_duty       <= 16'd240;
      cfg_q.zero_bit_duty      <= 16'd120;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dpce_front #(
    .NUM_CHANNELS       (NUM_CHANNELS),
    .NUM_DSHOT_CHANNELS (NUM_DSHOT_CHANNELS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .start_i      (start),
    .busy_o       (busy),
    .channel_i    (channel_i),
    .percent_q8_i (percent_q8_i),
    .queue_full_i (q_full),
    .queue_ctl_o  (qctl),
    .job_o        (job_in)
  );

  dpce_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (qctl),
    .job_i   (job_in),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (q_pop),
    .job_o   (job_out)
  );

  dpce_back #(
    .BUFFER_WORDS (BUFFER_WORDS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .empty_i         (q_empty),
    .pop_o           (q_pop),
    .job_i           (job_out),
    .result_strobe_o (result_strobe_o),
    .channel_out_o   (channel_out_o),
    .compare_value_o (compare_value_o),
    .is_dshot_o      (is_dshot_o),
    .last_o          (last_o)
  );

endmodule
